// ===== hw/rtl/psar_pkg.sv =====
// Package for the picture-unit scroll and address register block.
// Holds the item types, opcode, register and configuration codes and mirroring modes.
// Depends on nothing; every module of the block imports it.
package psar_pkg;

  localparam int InDataW  = 16;
  localparam int OutDataW = 72;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic OP_REG_WRITE = 1'b0;
  localparam logic OP_SCANLINE  = 1'b1;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [CfgIdxW-1:0] CFG_MIRROR_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_LOCK  = 2'd1;

  localparam logic [2:0] MIRROR_HORIZONTAL  = 3'd0;
  localparam logic [2:0] MIRROR_VERTICAL    = 3'd1;
  localparam logic [2:0] MIRROR_SINGLE_LOW  = 3'd2;
  localparam logic [2:0] MIRROR_SINGLE_HIGH = 3'd3;

  localparam logic [15:0] ACCESS_RESET = 16'h2000;
  localparam logic [15:0] NT_FIRST     = 16'h2000;
  localparam logic [15:0] NT_LAST      = 16'h3EFF;
  localparam logic [15:0] PAL_ALIAS    = 16'h3F10;

  typedef struct packed {
    logic       opcode;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic       first_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  mask_byte;
    logic [7:0]  control_byte;
    logic [2:0]  fine_x;
    logic [14:0] scroll_addr;
    logic [7:0]  out_data;
    logic [7:0]  oam_addr;
    logic        oam_we;
    logic        pal_alias_we;
    logic [1:0]  nt_bank;
    logic        nt_we;
    logic [15:0] vram_addr;
    logic        vram_we;
  } out_item_t;

endpackage

// ===== hw/rtl/psar_in_stage.sv =====
// Input register of the scroll and address register block.
// Holds one accepted transaction until the core consumes it; uses psar_pkg.
module psar_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psar_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output psar_pkg::in_item_t item
);
  import psar_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_valid ? 1'b1 : (valid_r && !advance);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== hw/rtl/psar_core.sv =====
// Register file, scroll counters and configuration of the picture-unit block.
// Updates the state and forms one result per consumed transaction; uses psar_pkg.
module psar_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [psar_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [psar_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           fire,
  input  psar_pkg::in_item_t             item,
  output psar_pkg::out_item_t            result
);
  import psar_pkg::*;

  logic [2:0]  mirror_mode_r;
  logic        write_lock_r;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [14:0] temp_r, temp_nxt;
  logic [14:0] cur_r, cur_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic        scroll_tog_r, scroll_tog_nxt;
  logic        addr_tog_r, addr_tog_nxt;
  logic [15:0] access_r, access_nxt;
  logic [7:0]  oam_ptr_r, oam_ptr_nxt;
  logic [14:0] reload;
  out_item_t   res;

  function automatic logic [14:0] step_y(input logic [14:0] v);
    logic [14:0] w;
    w = v;
    if (v[14:12] == 3'd7) begin
      w[14:12] = 3'd0;
      if (v[9:5] == 5'd29) begin
        w[11]  = ~v[11];
        w[9:5] = 5'd0;
      end else if (v[9:5] == 5'd31) begin
        w[9:5] = 5'd0;
      end else begin
        w[9:5] = v[9:5] + 5'd1;
      end
    end else begin
      w[14:12] = v[14:12] + 3'd1;
    end
    return w;
  endfunction

  function automatic logic [1:0] bank_of(input logic [2:0] mode, input logic [1:0] q);
    logic [1:0] b;
    case (mode)
      MIRROR_HORIZONTAL:  b = {1'b0, q[1]};
      MIRROR_VERTICAL:    b = {1'b0, q[0]};
      MIRROR_SINGLE_LOW:  b = 2'd0;
      MIRROR_SINGLE_HIGH: b = 2'd1;
      default:            b = q;
    endcase
    return b;
  endfunction

  assign reload = item.first_line ? temp_r : ((cur_r & 15'h7BE0) | (temp_r & 15'h041F));

  always_comb begin
    ctrl_nxt       = ctrl_r;
    mask_nxt       = mask_r;
    temp_nxt       = temp_r;
    cur_nxt        = cur_r;
    fine_x_nxt     = fine_x_r;
    scroll_tog_nxt = scroll_tog_r;
    addr_tog_nxt   = addr_tog_r;
    access_nxt     = access_r;
    oam_ptr_nxt    = oam_ptr_r;
    res            = '0;
    if (item.opcode == OP_SCANLINE) begin
      cur_nxt         = step_y(reload);
      res.scroll_addr = reload;
    end else begin
      case (item.reg_index)
        REG_CTRL: begin
          ctrl_nxt        = item.write_data;
          temp_nxt[11:10] = item.write_data[1:0];
        end
        REG_MASK: begin
          mask_nxt = item.write_data;
        end
        REG_OAM_ADDR: begin
          oam_ptr_nxt = item.write_data;
        end
        REG_OAM_DATA: begin
          res.oam_we   = 1'b1;
          res.oam_addr = oam_ptr_r;
          res.out_data = item.write_data;
          oam_ptr_nxt  = oam_ptr_r + 8'd1;
        end
        REG_SCROLL: begin
          if (!scroll_tog_r) begin
            temp_nxt[4:0]  = item.write_data[7:3];
            fine_x_nxt     = item.write_data[2:0];
            scroll_tog_nxt = 1'b1;
          end else begin
            temp_nxt[9:5]   = item.write_data[7:3];
            temp_nxt[14:12] = item.write_data[2:0];
            scroll_tog_nxt  = 1'b0;
          end
        end
        REG_ADDR: begin
          if (!addr_tog_r) begin
            temp_nxt     = {1'b0, item.write_data[5:0], temp_r[7:0]};
            addr_tog_nxt = 1'b1;
          end else begin
            temp_nxt     = {temp_r[14:8], item.write_data};
            cur_nxt      = temp_nxt;
            access_nxt   = {1'b0, temp_nxt};
            addr_tog_nxt = 1'b0;
          end
        end
        REG_DATA: begin
          if (!write_lock_r) begin
            res.vram_we   = 1'b1;
            res.vram_addr = access_r;
            res.out_data  = item.write_data;
            if (access_r >= NT_FIRST && access_r <= NT_LAST) begin
              res.nt_we   = 1'b1;
              res.nt_bank = bank_of(mirror_mode_r, access_r[11:10]);
            end
            res.pal_alias_we = (access_r == PAL_ALIAS);
            access_nxt = access_r + (ctrl_r[2] ? 16'h0020 : 16'h0001);
          end
        end
        default: begin
        end
      endcase
      res.scroll_addr = cur_nxt;
    end
    res.fine_x       = fine_x_nxt;
    res.control_byte = ctrl_nxt;
    res.mask_byte    = mask_nxt;
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_mode_r <= 3'd0;
      write_lock_r  <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MIRROR_MODE) begin
        mirror_mode_r <= cfg_data[2:0];
      end else if (cfg_index == CFG_WRITE_LOCK) begin
        write_lock_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r       <= 8'd0;
      mask_r       <= 8'd0;
      temp_r       <= 15'd0;
      cur_r        <= 15'd0;
      fine_x_r     <= 3'd0;
      scroll_tog_r <= 1'b0;
      addr_tog_r   <= 1'b0;
      access_r     <= ACCESS_RESET;
      oam_ptr_r    <= 8'd0;
    end else if (fire) begin
      ctrl_r       <= ctrl_nxt;
      mask_r       <= mask_nxt;
      temp_r       <= temp_nxt;
      cur_r        <= cur_nxt;
      fine_x_r     <= fine_x_nxt;
      scroll_tog_r <= scroll_tog_nxt;
      addr_tog_r   <= addr_tog_nxt;
      access_r     <= access_nxt;
      oam_ptr_r    <= oam_ptr_nxt;
    end
  end

endmodule

// ===== hw/rtl/psar_out_stage.sv =====
// Result register of the scroll and address register block.
// Holds one finished result until the downstream side takes it; uses psar_pkg.
module psar_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  psar_pkg::out_item_t result,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output psar_pkg::out_item_t out_item
);
  import psar_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign advance   = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result;
    end
  end

endmodule

// ===== hw/rtl/ppu_scroll_address_registers_unit.sv =====
// Top level of the picture-unit register file and scroll counters.
// Instantiates psar_in_stage, psar_core and psar_out_stage; uses psar_pkg.
//
// Channel   Direction  Payload
// in_       slave      tuser: opcode; tdata: reg_index, write_data, first_line
// out_      master     tdata: one result per input transaction
// cfg_      slave      cfg_index selects mirror_mode (0) or vram_write_lock (1)
//
// One transaction per cycle is sustained while out_tready is held high; a result passes through
// the input register and the result register around the core logic before it is offered.
// Reset is synchronous; no clearing pass follows it.
// A stalled result register holds the input register, which then stalls in_tready.
// Configuration writes are taken in every cycle.
module ppu_scroll_address_registers_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] opcode
  input  logic [0:0]                     in_tuser,
  // [2:0] reg_index, [10:3] write_data, [11] first_line, [15:12] zero
  input  logic [psar_pkg::InDataW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] vram_we, [16:1] vram_addr, [17] nt_we, [19:18] nt_bank, [20] pal_alias_we,
  // [21] oam_we, [29:22] oam_addr, [37:30] out_data, [52:38] scroll_addr,
  // [55:53] fine_x, [63:56] control_byte, [71:64] mask_byte
  output logic [psar_pkg::OutDataW-1:0]  out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psar_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [psar_pkg::CfgDataW-1:0]  cfg_data
);
  import psar_pkg::*;

  in_item_t  in_item;
  in_item_t  item;
  out_item_t result;
  out_item_t out_item;
  logic      item_valid;
  logic      advance;
  logic      fire;

  assign in_item.opcode     = in_tuser[0];
  assign in_item.reg_index  = in_tdata[2:0];
  assign in_item.write_data = in_tdata[10:3];
  assign in_item.first_line = in_tdata[11];

  assign fire      = item_valid && advance;
  assign cfg_ready = 1'b1;
  assign out_tdata = out_item;

  psar_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  psar_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  psar_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .result    (result),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for ppu_scroll_address_registers_unit.
// A clocked driver, receiver and monitor check every result against an in-bench predictor.
// Depends on psar_pkg and the ppu_scroll_address_registers_unit RTL.
module tb_top;
  import psar_pkg::*;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int MaxReports = 10;

  localparam logic [CfgIdxW-1:0] CfgSpareLow  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = 2'd3;

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_SPARSE,
    RDY_TOGGLE
  } ready_mode_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [0:0] in_tuser;
  logic [InDataW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ppu_scroll_address_registers_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Predicted register state of the block.
  logic [7:0]  ppu_ctrl_q;
  logic [7:0]  ppu_mask_q;
  logic [14:0] t_scroll;
  logic [14:0] v_scroll;
  logic [2:0]  fine_x_q;
  logic        scroll_second;
  logic        addr_second;
  logic [15:0] vram_ptr;
  logic [7:0]  oam_ptr;
  logic [2:0]  mirror_q;
  logic        lock_q;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int n_queued;
  int n_accepted;
  int err_count;
  int report_count;
  int idle_cycles;

  logic in_taken;
  logic out_taken;
  logic cfg_taken;
  logic hold_req;
  logic hold_done;
  int hold_left;
  int burst_left;
  int gap_left;
  int stretch_left;
  ready_mode_t ready_mode;
  in_item_t drv_item;
  out_item_t got_result;
  out_item_t want_result;

  function automatic logic [1:0] nt_bank_of(logic [2:0] mode, logic [1:0] quadrant);
    case (mode)
      MIRROR_HORIZONTAL:  return {1'b0, quadrant[1]};
      MIRROR_VERTICAL:    return {1'b0, quadrant[0]};
      MIRROR_SINGLE_LOW:  return 2'd0;
      MIRROR_SINGLE_HIGH: return 2'd1;
      default:            return quadrant;
    endcase
  endfunction

  function automatic logic [14:0] next_line_scroll(logic [14:0] v);
    logic [14:0] n;
    n = v;
    if (n[14:12] == 3'd7) begin
      n = n & 15'h0FFF;
      if (n[9:5] == 5'd29) begin
        n = (n ^ 15'h0800) & 15'h7C1F;
      end else if (n[9:5] == 5'd31) begin
        n = n & 15'h7C1F;
      end else begin
        n = n + 15'h0020;
      end
    end else begin
      n = n + 15'h1000;
    end
    return n;
  endfunction

  function automatic out_item_t predict_result(logic op, logic [2:0] ri, logic [7:0] d,
                                               logic fl);
    out_item_t r;
    logic [15:0] a;
    r = '0;
    if (op == OP_SCANLINE) begin
      if (fl) begin
        v_scroll = t_scroll;
      end else begin
        v_scroll = (v_scroll & 15'h7BE0) | (t_scroll & 15'h041F);
      end
      r.scroll_addr = v_scroll;
      v_scroll = next_line_scroll(v_scroll);
    end else begin
      case (ri)
        REG_CTRL: begin
          ppu_ctrl_q = d;
          t_scroll = (t_scroll & 15'h73FF) | {3'b0, d[1:0], 10'b0};
        end
        REG_MASK: begin
          ppu_mask_q = d;
        end
        REG_OAM_ADDR: begin
          oam_ptr = d;
        end
        REG_OAM_DATA: begin
          r.oam_we = 1'b1;
          r.oam_addr = oam_ptr;
          r.out_data = d;
          oam_ptr = oam_ptr + 8'd1;
        end
        REG_SCROLL: begin
          if (!scroll_second) begin
            t_scroll = (t_scroll & 15'h7FE0) | {10'b0, d[7:3]};
            fine_x_q = d[2:0];
            scroll_second = 1'b1;
          end else begin
            t_scroll = (t_scroll & 15'h0C1F) | {d[2:0], 2'b0, d[7:3], 5'b0};
            scroll_second = 1'b0;
          end
        end
        REG_ADDR: begin
          if (!addr_second) begin
            t_scroll = (t_scroll & 15'h00FF) | {1'b0, d[5:0], 8'b0};
            addr_second = 1'b1;
          end else begin
            t_scroll = (t_scroll & 15'h7F00) | {7'b0, d};
            v_scroll = t_scroll;
            vram_ptr = {1'b0, t_scroll};
            addr_second = 1'b0;
          end
        end
        REG_DATA: begin
          if (!lock_q) begin
            a = vram_ptr;
            r.vram_we = 1'b1;
            r.vram_addr = a;
            r.out_data = d;
            if (a >= NT_FIRST && a <= NT_LAST) begin
              r.nt_we = 1'b1;
              r.nt_bank = nt_bank_of(mirror_q, a[11:10]);
            end
            if (a == PAL_ALIAS) begin
              r.pal_alias_we = 1'b1;
            end
            vram_ptr = a + (ppu_ctrl_q[2] ? 16'h0020 : 16'h0001);
          end
        end
        default: begin
        end
      endcase
      r.scroll_addr = v_scroll;
    end
    r.fine_x = fine_x_q;
    r.control_byte = ppu_ctrl_q;
    r.mask_byte = ppu_mask_q;
    return r;
  endfunction

  function automatic string fmt_result(out_item_t r);
    return $sformatf({"vram_we=%0d vram_addr=%h nt_we=%0d nt_bank=%0d pal=%0d oam_we=%0d ",
                      "oam_addr=%h data=%h scroll=%h fine_x=%0d ctrl=%h mask=%h"},
                     r.vram_we, r.vram_addr, r.nt_we, r.nt_bank, r.pal_alias_we, r.oam_we,
                     r.oam_addr, r.out_data, r.scroll_addr, r.fine_x, r.control_byte,
                     r.mask_byte);
  endfunction

  // Monitor: predicts on every input transaction and checks every output transaction.
  always @(posedge clk) begin
    in_taken = 1'b0;
    out_taken = 1'b0;
    cfg_taken = 1'b0;
    if (rst_n) begin
      cfg_taken = cfg_valid && cfg_ready;
      in_taken = in_tvalid && in_tready;
      out_taken = out_tvalid && out_tready;
      if (cfg_taken) begin
        if (cfg_index == CFG_MIRROR_MODE) begin
          mirror_q = cfg_data[2:0];
        end else if (cfg_index == CFG_WRITE_LOCK) begin
          lock_q = cfg_data[0];
        end
      end
      if (in_taken) begin
        expected_results.push_back(predict_result(in_tuser[0], in_tdata[2:0], in_tdata[10:3],
                                                  in_tdata[11]));
        n_accepted++;
      end
      if (out_taken) begin
        got_result = out_item_t'(out_tdata);
        if (expected_results.size() == 0) begin
          err_count++;
          if (report_count < MaxReports) begin
            report_count++;
            $display("Unexpected result: %s", fmt_result(got_result));
          end
        end else begin
          want_result = expected_results.pop_front();
          if (got_result !== want_result) begin
            err_count++;
            if (report_count < MaxReports) begin
              report_count++;
              $display("Mismatch\n  expected: %s\n  actual:   %s", fmt_result(want_result),
                       fmt_result(got_result));
            end
          end
        end
      end
      if (in_taken || out_taken || cfg_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Timeout: no transaction for %0d cycles", StallLimit);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // Driver: offers pending items in bursts separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drv_item = pending_items.pop_front();
        in_tuser <= drv_item.opcode;
        in_tdata <= {4'b0, drv_item.first_line, drv_item.write_data, drv_item.reg_index};
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(30, 80);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls in stretches of changing pattern, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          ready_mode = ready_mode_t'($urandom_range(0, 3));
          stretch_left = $urandom_range(10, 80);
        end
        stretch_left--;
        case (ready_mode)
          RDY_ALWAYS: out_tready <= 1'b1;
          RDY_RANDOM: out_tready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:    out_tready <= ~out_tready;
        endcase
      end
    end
  end

  task automatic push_item(logic op, logic [2:0] ri, logic [7:0] d, logic fl);
    in_item_t it;
    it.opcode = op;
    it.reg_index = ri;
    it.write_data = d;
    it.first_line = fl;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic push_reg(logic [2:0] ri, logic [7:0] d);
    push_item(OP_REG_WRITE, ri, d, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_line(logic fl);
    push_item(OP_SCANLINE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), fl);
  endtask

  task automatic push_random_traffic(int n);
    int count;
    int k;
    logic [7:0] hi;
    count = 0;
    while (count < n) begin
      k = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1: begin
          hi = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 9) < 7) begin
            hi[5:0] = 6'($urandom_range(6'h20, 6'h3F));
          end
          push_reg(REG_ADDR, hi);
          push_reg(REG_ADDR, 8'($urandom_range(0, 255)));
          for (int i = 0; i < k; i++) begin
            push_reg(REG_DATA, 8'($urandom_range(0, 255)));
          end
          count += k + 2;
        end
        2: begin
          push_reg(REG_SCROLL, 8'($urandom_range(0, 255)));
          push_reg(REG_SCROLL, 8'($urandom_range(0, 255)));
          count += 2;
        end
        3: begin
          push_reg(REG_CTRL, 8'($urandom_range(0, 255)));
          count += 1;
        end
        4: begin
          push_reg(REG_MASK, 8'($urandom_range(0, 255)));
          count += 1;
        end
        5: begin
          push_reg(REG_OAM_ADDR, 8'($urandom_range(0, 255)));
          for (int i = 0; i < k; i++) begin
            push_reg(REG_OAM_DATA, 8'($urandom_range(0, 255)));
          end
          count += k + 1;
        end
        6: begin
          push_line(1'b1);
          for (int i = 0; i < k; i++) begin
            push_line(1'b0);
          end
          count += k + 1;
        end
        7: begin
          push_reg(REG_STATUS, 8'($urandom_range(0, 255)));
          count += 1;
        end
        default: begin
          push_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          count += 1;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
    end while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(logic [2:0] mode, logic lock);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    v[2:0] = mode;
    write_cfg(CFG_MIRROR_MODE, v);
    v = 8'($urandom_range(0, 255));
    v[0] = lock;
    write_cfg(CFG_WRITE_LOCK, v);
  endtask

  logic [2:0] phase_mode[8] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
  logic       phase_lock[8] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    cfg_taken = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    burst_left = 0;
    gap_left = 0;
    stretch_left = 0;
    ready_mode = RDY_ALWAYS;
    n_queued = 0;
    n_accepted = 0;
    err_count = 0;
    report_count = 0;
    idle_cycles = 0;
    ppu_ctrl_q = '0;
    ppu_mask_q = '0;
    t_scroll = '0;
    v_scroll = '0;
    fine_x_q = '0;
    scroll_second = 1'b0;
    addr_second = 1'b0;
    vram_ptr = ACCESS_RESET;
    oam_ptr = '0;
    mirror_q = MIRROR_HORIZONTAL;
    lock_q = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_mode(MIRROR_HORIZONTAL, 1'b0);
    push_reg(REG_CTRL, 8'hFF);
    push_reg(REG_CTRL, 8'h00);
    push_reg(REG_MASK, 8'hFF);
    push_reg(REG_MASK, 8'h00);
    push_reg(REG_STATUS, 8'hFF);
    push_reg(REG_OAM_ADDR, 8'hFF);
    push_reg(REG_OAM_DATA, 8'h00);
    push_reg(REG_OAM_DATA, 8'hFF);
    push_reg(REG_SCROLL, 8'hFF);
    push_reg(REG_SCROLL, 8'hEF);
    push_line(1'b1);
    push_line(1'b0);
    push_reg(REG_SCROLL, 8'h00);
    push_reg(REG_SCROLL, 8'hFF);
    push_line(1'b1);
    push_reg(REG_ADDR, 8'hFF);
    push_reg(REG_ADDR, 8'h10);
    push_reg(REG_DATA, 8'hFF);
    push_reg(REG_ADDR, 8'h3E);
    push_reg(REG_ADDR, 8'hFF);
    push_reg(REG_DATA, 8'h00);
    push_reg(REG_DATA, 8'h5A);
    push_reg(REG_ADDR, 8'h1F);
    push_reg(REG_ADDR, 8'hFF);
    push_reg(REG_DATA, 8'hA5);
    push_reg(REG_DATA, 8'h3C);
    push_item(OP_SCANLINE, REG_DATA, 8'hFF, 1'b0);
    wait_drained();

    write_cfg(CfgSpareLow, 8'($urandom_range(0, 255)));
    write_cfg(CfgSpareHigh, 8'($urandom_range(0, 255)));

    for (int p = 0; p < 8; p++) begin
      set_mode(phase_mode[p], phase_lock[p]);
      push_random_traffic(58);
      if (p == 2) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      wait_drained();
    end

    // Step the data port across the end of the nametable range and the palette alias.
    set_mode(MIRROR_VERTICAL, 1'b0);
    if (addr_second) begin
      push_reg(REG_ADDR, 8'($urandom_range(0, 255)));
    end
    push_reg(REG_CTRL, 8'h00);
    push_reg(REG_ADDR, 8'h3E);
    push_reg(REG_ADDR, 8'hF8);
    for (int i = 0; i < 32; i++) begin
      push_reg(REG_DATA, 8'($urandom_range(0, 255)));
    end
    wait_drained();

    repeat (8) @(negedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
